>>> hdl/gray_code_kernel_filter_bank_top_assert.svh
// assertion macros for the gray-code kernel filter bank
`ifndef GRAY_CODE_KERNEL_FILTER_BANK_TOP_ASSERT_SVH
`define GRAY_CODE_KERNEL_FILTER_BANK_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// clocked check, masked while reset is low
`define GCKF_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("%m: check failed");
// clocked check that also holds during reset
`define GCKF_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("%m: check failed");
`else
`define GCKF_ASSERT(label, prop)
`define GCKF_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> hdl/gckf_pkg.sv
// shared types and constants of the gray-code kernel filter bank
package gckf_pkg;

    localparam int PROJ_W     = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int LOG2_W     = 3;
    localparam int COUNT_W    = 5;

    typedef logic signed [PROJ_W-1:0] t_proj;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_LOG2 = 2'd0,
        CFG_BASE_COUNT  = 2'd1
    } t_cfg_idx;

    localparam logic [LOG2_W-1:0]  KERNEL_LOG2_RST = 3'd2;
    localparam logic [COUNT_W-1:0] BASE_COUNT_RST  = 5'd4;

    // clamped configuration
    typedef struct packed {
        logic [LOG2_W-1:0]  log2;
        logic [COUNT_W-1:0] count;
    } t_cfg_sel;

    // per-cycle datapath controls
    typedef struct packed {
        logic samp_wr;
        logic samp_rd;
        logic sum_init;
        logic sum_acc;
        logic sum_gate;
        logic kern_rd;
        logic kern_ok;
        logic kern_sgn;
        logic kern_step;
        logic kern_first;
        logic kern_zero;
        logic out_load;
        logic out_last;
    } t_dp_ctrl;

endpackage

>>> hdl/gckf_if.sv
// handshake channels of the gray-code kernel filter bank
interface gckf_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_req;

    modport source (output valid, sample, start_req, input ready);
    modport sink   (input valid, sample, start_req, output ready);
endinterface

interface gckf_out_if #(
    parameter int IDX_W = 4
);
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   kernel_index;
    gckf_pkg::t_proj    projection;
    logic               last;

    modport source (output valid, kernel_index, projection, last, input ready);
    modport sink   (input valid, kernel_index, projection, last, output ready);
endinterface

interface gckf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gckf_pkg::CFG_IDX_W-1:0]  index;
    logic [gckf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/gckf_cfg.sv
// configuration registers with range clamping
module gckf_cfg #(
    parameter int MAX_KERNEL_LOG2 = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    gckf_cfg_if.sink            i_cfg,
    output gckf_pkg::t_cfg_sel  o_cfg_sel
);
    localparam int CNT_W = MAX_KERNEL_LOG2 + 1;
    localparam int CMP_W = (CNT_W > gckf_pkg::COUNT_W) ? CNT_W : gckf_pkg::COUNT_W;

    logic [gckf_pkg::LOG2_W-1:0]  r_kernel_log2;
    logic [gckf_pkg::COUNT_W-1:0] r_base_count;
    logic [gckf_pkg::LOG2_W-1:0]  log2_cl;
    logic [CMP_W-1:0]             klen;
    logic [CMP_W-1:0]             cnt_ext;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_log2 <= gckf_pkg::KERNEL_LOG2_RST;
            r_base_count  <= gckf_pkg::BASE_COUNT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == gckf_pkg::CFG_KERNEL_LOG2) begin
                r_kernel_log2 <= i_cfg.data[gckf_pkg::LOG2_W-1:0];
            end else if (i_cfg.index == gckf_pkg::CFG_BASE_COUNT) begin
                r_base_count <= i_cfg.data[gckf_pkg::COUNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_kernel_log2 < 3'd1) begin
            log2_cl = 3'd1;
        end else if (r_kernel_log2 > gckf_pkg::LOG2_W'(MAX_KERNEL_LOG2)) begin
            log2_cl = gckf_pkg::LOG2_W'(MAX_KERNEL_LOG2);
        end else begin
            log2_cl = r_kernel_log2;
        end
        klen    = CMP_W'(1) << log2_cl;
        cnt_ext = CMP_W'(r_base_count);
        o_cfg_sel.log2 = log2_cl;
        // count never exceeds the kernel length
        if (r_base_count < 5'd1) begin
            o_cfg_sel.count = 5'd1;
        end else if (cnt_ext > klen) begin
            o_cfg_sel.count = gckf_pkg::COUNT_W'(klen);
        end else begin
            o_cfg_sel.count = r_base_count;
        end
    end

endmodule

>>> hdl/gckf_ctrl.sv
// sequencer: box-sum sweep, kernel sweep and result handshake
`include "gray_code_kernel_filter_bank_top_assert.svh"
module gckf_ctrl #(
    parameter int MAX_KERNEL_LOG2 = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gckf_pkg::t_cfg_sel          i_cfg_sel,
    input  logic                        i_in_valid,
    input  logic                        i_start_req,
    output logic                        o_in_ready,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output gckf_pkg::t_dp_ctrl          o_ctrl,
    output logic [MAX_KERNEL_LOG2-1:0]  o_wp,
    output logic [MAX_KERNEL_LOG2-1:0]  o_samp_slot,
    output logic [MAX_KERNEL_LOG2-1:0]  o_kern_rd_k,
    output logic [MAX_KERNEL_LOG2-1:0]  o_kern_slot,
    output logic [MAX_KERNEL_LOG2-1:0]  o_kern_wr_k
);
    localparam int MAX_L = MAX_KERNEL_LOG2;
    localparam int MAXK  = 1 << MAX_L;
    localparam int CNT_W = MAX_L + 1;
    localparam int CMP_W = (CNT_W > gckf_pkg::COUNT_W) ? CNT_W : gckf_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BOX  = 3'b010,
        ST_KERN = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [MAX_L-1:0]   r_d, n_d;
    logic [MAX_L-1:0]   r_k, n_k;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [MAX_L-1:0]   r_wp, n_wp;
    logic               r_out_valid, n_out_valid;

    logic [CNT_W-1:0]   klen;
    logic [MAX_L-1:0]   nk;
    logic [CNT_W-1:0]   delta;
    logic [CMP_W-1:0]   k_ext, b_ext;
    logic               emit, can_load;

    // lag exponent of kernel i: high gray bits shared with kernel i-1
    function automatic logic [2:0] lag_log2(input logic [MAX_L-1:0] i,
                                            input logic [2:0] l);
        int t;
        t = 0;
        for (int b = MAX_L - 1; b >= 0; b--) begin
            if (i[b]) begin
                t = b;
            end
        end
        return 3'(int'(l) - 1 - t);
    endfunction

    // sign: the gray bit that flips between kernel i-1 and kernel i
    function automatic logic kern_sign(input logic [MAX_L-1:0] i);
        logic [MAX_L-1:0] g, low;
        g   = i ^ (i >> 1);
        low = i & (~i + MAX_L'(1));
        return |(g & low);
    endfunction

    assign klen     = CNT_W'(1) << i_cfg_sel.log2;
    assign nk       = r_k + MAX_L'(1);
    assign delta    = CNT_W'(1) << lag_log2(nk, i_cfg_sel.log2);
    assign k_ext    = CMP_W'(r_k);
    assign b_ext    = CMP_W'(i_cfg_sel.count);
    assign emit     = k_ext < b_ext;
    assign can_load = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_wp        = r_wp;
    assign o_kern_wr_k = r_k;
    assign o_kern_rd_k = nk;
    assign o_kern_slot = r_wp - delta[MAX_L-1:0];

    always_comb begin
        n_state     = r_state;
        n_d         = r_d;
        n_k         = r_k;
        n_pos       = r_pos;
        n_wp        = r_wp;
        o_ctrl      = '0;
        o_samp_slot = r_wp - MAX_L'(1);

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.samp_wr  = 1'b1;
                    o_ctrl.sum_init = 1'b1;
                    o_ctrl.samp_rd  = 1'b1;
                    n_d             = MAX_L'(1);
                    n_state         = ST_BOX;
                    if (i_start_req) begin
                        n_pos = '0;
                    end
                end
            end
            ST_BOX: begin
                o_ctrl.sum_acc  = 1'b1;
                o_ctrl.sum_gate = CNT_W'(r_d) <= r_pos;
                o_samp_slot     = r_wp - (r_d + MAX_L'(1));
                if ((CNT_W'(r_d) + CNT_W'(1)) < klen) begin
                    o_ctrl.samp_rd = 1'b1;
                    n_d            = r_d + MAX_L'(1);
                end else begin
                    n_k     = '0;
                    n_state = ST_KERN;
                end
            end
            ST_KERN: begin
                if (!emit || can_load) begin
                    o_ctrl.kern_step  = 1'b1;
                    o_ctrl.kern_first = (r_k == '0);
                    o_ctrl.kern_zero  = CNT_W'(r_k) >= klen;
                    o_ctrl.out_load   = emit;
                    o_ctrl.out_last   = (k_ext + CMP_W'(1)) == b_ext;
                    o_ctrl.kern_rd    = 1'b1;
                    o_ctrl.kern_ok    = delta <= r_pos;
                    o_ctrl.kern_sgn   = kern_sign(nk);
                    if (r_k == MAX_L'(MAXK - 1)) begin
                        n_state = ST_IDLE;
                        n_wp    = r_wp + MAX_L'(1);
                        if (r_pos != CNT_W'(MAXK)) begin
                            n_pos = r_pos + CNT_W'(1);
                        end
                    end else begin
                        n_k = nk;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_ctrl.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_d         <= '0;
            r_k         <= '0;
            r_pos       <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_d         <= n_d;
            r_k         <= n_k;
            r_pos       <= n_pos;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
        end
    end

    `GCKF_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (r_state == ST_IDLE && !r_out_valid))
    `GCKF_ASSERT(a_pos_sat, r_pos <= CNT_W'(MAXK))
    `GCKF_ASSERT(a_no_overwrite, (r_out_valid && !i_out_ready) |-> !o_ctrl.out_load)
    `GCKF_ASSERT(a_box_lag, (r_state == ST_BOX) |-> (CNT_W'(r_d) < klen))
    `GCKF_ASSERT(a_wp_bump, (r_state == ST_KERN && n_state == ST_IDLE) |=> ((r_wp - $past(r_wp)) == MAX_L'(1)))

endmodule

>>> hdl/gckf_datapath.sv
// history memories, accumulate and recurrence adders, and result register
module gckf_datapath #(
    parameter int MAX_KERNEL_LOG2 = 4,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic                            i_clk,
    input  gckf_pkg::t_dp_ctrl              i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample,
    input  logic [MAX_KERNEL_LOG2-1:0]      i_wp,
    input  logic [MAX_KERNEL_LOG2-1:0]      i_samp_slot,
    input  logic [MAX_KERNEL_LOG2-1:0]      i_kern_rd_k,
    input  logic [MAX_KERNEL_LOG2-1:0]      i_kern_slot,
    input  logic [MAX_KERNEL_LOG2-1:0]      i_kern_wr_k,
    output logic [MAX_KERNEL_LOG2-1:0]      o_kernel_index,
    output gckf_pkg::t_proj                 o_projection,
    output logic                            o_last
);
    localparam int MAX_L = MAX_KERNEL_LOG2;
    localparam int MAXK  = 1 << MAX_L;
    localparam int AW    = 2 * MAX_L;

    // sample ring and per-kernel value rings, one slot per position
    logic signed [SAMPLE_WIDTH-1:0] r_samp_mem [MAXK];
    gckf_pkg::t_proj                r_kern_mem [MAXK*MAXK];

    logic signed [SAMPLE_WIDTH-1:0] r_samp_rd;
    gckf_pkg::t_proj                r_sum, r_prev, r_pd, r_qd;
    logic                           r_kok, r_ksgn;
    gckf_pkg::t_proj                r_out_proj;
    logic [MAX_L-1:0]               r_out_idx;
    logic                           r_out_last;

    logic [AW-1:0]      wr_addr, rd_addr_a, rd_addr_b;
    gckf_pkg::t_proj    pd, qd, diff, cur, addend;

    assign wr_addr   = {i_kern_wr_k, i_wp};
    assign rd_addr_a = {i_kern_rd_k, i_kern_slot};
    assign rd_addr_b = {i_kern_rd_k - MAX_L'(1), i_kern_slot};

    always_comb begin
        addend = i_ctrl.sum_gate ? gckf_pkg::t_proj'(r_samp_rd) : '0;
        pd     = r_kok ? r_pd : '0;
        qd     = r_kok ? r_qd : '0;
        diff   = r_ksgn ? (qd - pd) : (pd - qd);
        if (i_ctrl.kern_first) begin
            cur = r_sum;
        end else if (i_ctrl.kern_zero) begin
            cur = '0;
        end else begin
            cur = diff - r_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.samp_wr) begin
            r_samp_mem[i_wp] <= i_sample;
        end
        if (i_ctrl.samp_rd) begin
            r_samp_rd <= r_samp_mem[i_samp_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.kern_step) begin
            r_kern_mem[wr_addr] <= cur;
        end
        if (i_ctrl.kern_rd) begin
            r_pd   <= r_kern_mem[rd_addr_a];
            r_qd   <= r_kern_mem[rd_addr_b];
            r_kok  <= i_ctrl.kern_ok;
            r_ksgn <= i_ctrl.kern_sgn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum_init) begin
            r_sum <= gckf_pkg::t_proj'(i_sample);
        end else if (i_ctrl.sum_acc) begin
            r_sum <= r_sum + addend;
        end
        if (i_ctrl.kern_step) begin
            r_prev <= cur;
        end
        if (i_ctrl.out_load) begin
            r_out_proj <= cur;
            r_out_idx  <= i_kern_wr_k;
            r_out_last <= i_ctrl.out_last;
        end
    end

    assign o_kernel_index = r_out_idx;
    assign o_projection   = r_out_proj;
    assign o_last         = r_out_last;

endmodule

>>> hdl/gray_code_kernel_filter_bank_top.sv
// top level of the gray-code kernel filter bank
// first result of a sample is registered after its box-sum sweep, at the first kernel step
// a new sample is taken only once the previous one has finished its box-sum sweep over
//   the sample ring and its kernel sweep with one kernel-ring write per kernel slot
// results leave one per cycle while the output side keeps taking them
// reset (synchronous, active low) idles the sequencer, clears position count,
//   ring pointer and output valid, and restores the configuration defaults
module gray_code_kernel_filter_bank_top #(
    parameter int MAX_KERNEL_LOG2 = 4,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gckf_in_if.sink     i_in,
    gckf_out_if.source  o_out,
    gckf_cfg_if.sink    i_cfg
);
    localparam int MAX_L = MAX_KERNEL_LOG2;

    gckf_pkg::t_cfg_sel cfg_sel;
    gckf_pkg::t_dp_ctrl dp_ctrl;
    logic [MAX_L-1:0]   wp, samp_slot, kern_rd_k, kern_slot, kern_wr_k;
    logic               in_ready, out_valid;
    logic [MAX_L-1:0]   res_idx;
    gckf_pkg::t_proj    res_proj;
    logic               res_last;

    // configuration registers; write only between samples (the block does not enforce it)
    gckf_cfg #(
        .MAX_KERNEL_LOG2 (MAX_KERNEL_LOG2)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_cfg_sel (cfg_sel)
    );

    // sequencer: accept, box-sum sweep, kernel sweep, result handshake
    gckf_ctrl #(
        .MAX_KERNEL_LOG2 (MAX_KERNEL_LOG2)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_sel   (cfg_sel),
        .i_in_valid  (i_in.valid),
        .i_start_req (i_in.start_req),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_ctrl      (dp_ctrl),
        .o_wp        (wp),
        .o_samp_slot (samp_slot),
        .o_kern_rd_k (kern_rd_k),
        .o_kern_slot (kern_slot),
        .o_kern_wr_k (kern_wr_k)
    );

    // rings, accumulate / recurrence adders and output register
    gckf_datapath #(
        .MAX_KERNEL_LOG2 (MAX_KERNEL_LOG2),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_ctrl         (dp_ctrl),
        .i_sample       (i_in.sample),
        .i_wp           (wp),
        .i_samp_slot    (samp_slot),
        .i_kern_rd_k    (kern_rd_k),
        .i_kern_slot    (kern_slot),
        .i_kern_wr_k    (kern_wr_k),
        .o_kernel_index (res_idx),
        .o_projection   (res_proj),
        .o_last         (res_last)
    );

    // input beat taken only while the sequencer is idle
    assign i_in.ready = in_ready;

    // result beat straight from the output register
    assign o_out.valid        = out_valid;
    assign o_out.kernel_index = res_idx;
    assign o_out.projection   = res_proj;
    assign o_out.last         = res_last;

endmodule
